// File: rtl/core/rsum_pkg.sv
package rsum_pkg;

   localparam int CFG_W   = 11;
   localparam int POS_W   = 11;
   localparam int DELTA_W = 16;
   localparam int SUM_W   = 32;
   localparam int FUNC_W  = 2;
   localparam int APB_W   = 32;
   localparam int PADDR_W = 2;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

   localparam logic [PADDR_W-1:0] ADDR_POSITIONS_IN_USE = PADDR_W'(0);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_QUERY = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_Q_CHK,
      ST_Q_ACC,
      ST_Q_OUT
   } state_type;

endpackage

// File: rtl/core/rsum_ram.sv
module rsum_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/range_sum_tree.sv
// Add: one read and one write per tree level, after the accepting cycle.
// Query: up to two node reads per level plus one step per level; the result is
// handed over from ST_Q_OUT only while the result register is free;
// one word at a time, set by the single node memory and its registered read.
// Clear: one node per cycle, 2*MAX_POSITIONS nodes; reset starts the same clearing pass
// and restores positions_in_use to 1024; configuration writes are taken throughout.
module range_sum_tree
   import rsum_pkg::*;
#(
   parameter int MAX_POSITIONS = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [FUNC_W-1:0]         req_func,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [DELTA_W-1:0] req_delta,
   input  logic [POS_W-1:0]          req_range_low,
   input  logic [POS_W-1:0]          req_range_high,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [SUM_W-1:0]   rsp_range_sum,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [PADDR_W-1:0]        csr_paddr,
   input  logic [APB_W-1:0]          csr_pwdata,
   output logic [APB_W-1:0]          csr_prdata,
   output logic                      csr_pready
);

   localparam int DEPTH = 2 * MAX_POSITIONS;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = AW + 1;
   localparam int PW    = $clog2(MAX_POSITIONS + 1);
   localparam int NW    = (PW > POS_W) ? PW : POS_W;
   localparam logic [AW-1:0] LAST_NODE = AW'(DEPTH - 1);

   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  cfg_ff;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [IW-1:0]     lo_ff, lo_in;
   logic [IW-1:0]     hi_ff, hi_in;
   logic [SUM_W-1:0]  delta_ff, delta_in;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  rsp_sum_ff, rsp_sum_in;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [SUM_W-1:0]  ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [SUM_W-1:0]  ram_rd_data;

   logic [NW-1:0]     bound;
   logic [NW-1:0]     pos_x;
   logic [POS_W-1:0]  lo_cut;
   logic [NW-1:0]     hi_cut;
   logic              add_ok;
   logic              query_ok;
   logic              csr_write;
   logic              req_take;

   rsum_ram #(
      .WIDTH (SUM_W),
      .DEPTH (DEPTH)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == ADDR_POSITIONS_IN_USE);
   assign csr_prdata = APB_W'(cfg_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_write) begin
         cfg_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   assign bound    = (NW'(cfg_ff) > NW'(MAX_POSITIONS)) ? NW'(MAX_POSITIONS) : NW'(cfg_ff);
   assign pos_x    = NW'(req_position);
   assign add_ok   = (pos_x != '0) && (pos_x <= bound);
   assign lo_cut   = (req_range_low == '0) ? POS_W'(1) : req_range_low;
   assign hi_cut   = (NW'(req_range_high) > bound) ? bound : NW'(req_range_high);
   assign query_ok = NW'(lo_cut) <= hi_cut;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      delta_in     = delta_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_sum_in   = rsp_sum_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = lo_ff[AW-1:0];
      ram_wr_data  = ram_rd_data + delta_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = lo_ff[AW-1:0];
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == LAST_NODE) begin
               clr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               case (func_type'(req_func))
                  FUNC_ADD: begin
                     lo_in    = IW'(MAX_POSITIONS) + IW'(req_position) - IW'(1);
                     delta_in = SUM_W'(req_delta);
                     if (add_ok) begin
                        state_in = ST_ADD_RD;
                     end
                  end
                  FUNC_QUERY: begin
                     lo_in  = IW'(MAX_POSITIONS) + IW'(lo_cut) - IW'(1);
                     hi_in  = IW'(MAX_POSITIONS) + IW'(hi_cut);
                     acc_in = '0;
                     state_in = query_ok ? ST_Q_CHK : ST_Q_OUT;
                  end
                  FUNC_CLEAR: begin
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ADD_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            ram_wr_en = 1'b1;
            lo_in     = lo_ff >> 1;
            state_in  = ((lo_ff >> 1) == '0) ? ST_IDLE : ST_ADD_RD;
         end
         ST_Q_CHK: begin
            if (lo_ff >= hi_ff) begin
               state_in = ST_Q_OUT;
            end else if (lo_ff[0]) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = lo_ff[AW-1:0];
               lo_in       = lo_ff + IW'(1);
               state_in    = ST_Q_ACC;
            end else if (hi_ff[0]) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(hi_ff - IW'(1));
               hi_in       = hi_ff - IW'(1);
               state_in    = ST_Q_ACC;
            end else begin
               lo_in = lo_ff >> 1;
               hi_in = hi_ff >> 1;
            end
         end
         ST_Q_ACC: begin
            acc_in   = acc_ff + ram_rd_data;
            state_in = ST_Q_CHK;
         end
         ST_Q_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      delta_ff   <= delta_in;
      acc_ff     <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en && ram_rd_en |-> ram_wr_addr != ram_rd_addr)
      else $error("node read and write hit the same entry");

   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_Q_OUT))
      else $error("result word raised outside query completion");

   a_add_node_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ADD_WR |-> lo_ff != '0 && $past(state_ff == ST_ADD_RD))
      else $error("add write-back without a preceding node read");

endmodule
